FILE: sv/kemn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kemn_pkg
// Shared types and constants for the key edge to MIDI note encoder.
// ----------------------------------------------------------------------------
package kemn_pkg;

  // Key scan geometry
  localparam int KEY_COUNT   = 12;
  localparam int SCAN_BITS   = 12;
  localparam int KEY_SCAN    = (KEY_COUNT < SCAN_BITS) ? KEY_COUNT : SCAN_BITS;
  localparam int KEY_CNT_W   = $clog2(KEY_SCAN + 1);
  localparam int KEY_IDX_W   = (KEY_SCAN > 1) ? $clog2(KEY_SCAN) : 1;

  // Chord slots (at most three offset registers exist)
  localparam int CHORD_SLOTS = 3;
  localparam int CHORD_REGS  = 3;
  localparam int SLOT_W      = $clog2(CHORD_SLOTS + 1);

  // Stream widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  // MIDI constants
  localparam logic [3:0] CIN_NOTE_ON   = 4'h9;
  localparam logic [3:0] CIN_NOTE_OFF  = 4'h8;
  localparam logic [3:0] CIN_STATUS    = 4'h0;
  localparam logic [7:0] STS_NOTE_ON   = 8'h90;
  localparam logic [7:0] STS_NOTE_OFF  = 8'h80;
  localparam logic [6:0] NOTE_VELOCITY = 7'd64;
  localparam logic [7:0] NOTE_NONE     = 8'd255;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OCTAVE  = 3'd0,
    REG_DISCO   = 3'd1,
    REG_CHORD_A = 3'd2,
    REG_CHORD_B = 3'd3,
    REG_CHORD_C = 3'd4
  } reg_index_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_STATUS   = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_KEY,
    ST_EMIT,
    ST_NEXT,
    ST_STATUS
  } state_t;

endpackage

`default_nettype wire

FILE: sv/key_edge_midi_note_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_edge_midi_note_encoder_top
// Compares each key scan with the previous one and emits MIDI note-on /
// note-off packets (with chord notes) followed by one end-of-scan status.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer when         Payload
//  s_axis    in         s_tvalid & s_tready   tdata: key_levels
//  m_axis    out        m_tvalid & m_tready   tdata/tuser: packet, tlast: last
//  cfg       in         cfg_valid & cfg_ready cfg_index, cfg_data
//
//  The sequencer steps through each key of a scan and, for each key that
//  changed, through the base note and every chord slot; the single shared
//  8-bit adder of the sequencer (octave base, key step, chord sums) serves
//  all these steps. s_tready is high only while idle. A stalled m_tready
//  holds the sequencer at the next packet; one result register sits on the
//  output. Reset is synchronous: no key pressed, count zero.
// ----------------------------------------------------------------------------
module key_edge_midi_note_encoder_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // slave stream: [11:0] key_levels, [15:12] zero
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [kemn_pkg::IN_TDATA_W-1:0]     s_tdata,
  // master stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [3:0] code_index, [11:4] status_byte, [19:12] pitch, [26:20] velocity,
  // [30:27] led_pattern, [38:31] latest_note, [39] zero
  output logic [kemn_pkg::OUT_TDATA_W-1:0]         m_tdata,
  // [1:0] kind
  output logic [1:0]                               m_tuser,
  output logic                                     m_tlast,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [kemn_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [kemn_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import kemn_pkg::*;

  // Configuration registers
  logic [3:0] octave;
  logic       disco_enable;
  logic [7:0] chord_reg [CHORD_REGS];

  // Scan state
  state_t               state, state_next;
  logic [SCAN_BITS-1:0] previous_keys, previous_keys_next;
  logic [KEY_SCAN-1:0]  edge_on, edge_on_next;
  logic [KEY_SCAN-1:0]  edge_off, edge_off_next;
  logic [KEY_CNT_W-1:0] key_cnt, key_cnt_next;
  logic [SLOT_W-1:0]    slot, slot_next;
  logic                 key_on, key_on_next;
  logic [7:0]           base, base_next;
  logic [7:0]           note_on_count, note_on_count_next;
  logic [7:0]           latest_pressed, latest_pressed_next;

  // Output register
  logic                   out_valid, out_valid_next;
  logic [OUT_TDATA_W-1:0] out_data, out_data_next;
  logic [1:0]             out_user, out_user_next;
  logic                   out_last, out_last_next;

  // Shared adder
  logic [7:0] add_a, add_b, add_sum;
  assign add_sum = add_a + add_b;

  logic [SCAN_BITS-1:0] cur_keys;
  logic [7:0]           chord_off;
  logic                 out_free;
  logic                 s_fire;

  assign cur_keys  = s_tdata[SCAN_BITS-1:0];
  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;
  assign m_tlast  = out_last;

  // Chord offset of the current slot (slot 0 is the base note)
  always_comb begin
    chord_off = 8'd0;
    for (int s = 0; s < CHORD_SLOTS; s++) begin
      if (slot == SLOT_W'(s + 1)) chord_off = chord_reg[s];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      octave       <= 4'd0;
      disco_enable <= 1'b0;
      for (int r = 0; r < CHORD_REGS; r++) chord_reg[r] <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OCTAVE:  octave       <= cfg_data[3:0];
        REG_DISCO:   disco_enable <= cfg_data[0];
        REG_CHORD_A: chord_reg[0] <= cfg_data;
        REG_CHORD_B: chord_reg[1] <= cfg_data;
        REG_CHORD_C: chord_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: next state, adder operands and output loading
  always_comb begin
    state_next          = state;
    previous_keys_next  = previous_keys;
    edge_on_next        = edge_on;
    edge_off_next       = edge_off;
    key_cnt_next        = key_cnt;
    slot_next           = slot;
    key_on_next         = key_on;
    base_next           = base;
    note_on_count_next  = note_on_count;
    latest_pressed_next = latest_pressed;
    out_valid_next      = out_valid && !m_tready;
    out_data_next       = out_data;
    out_user_next       = out_user;
    out_last_next       = out_last;
    add_a               = base;
    add_b               = 8'd0;

    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          edge_on_next        = KEY_SCAN'(~cur_keys & previous_keys);
          edge_off_next       = KEY_SCAN'(cur_keys & ~previous_keys);
          previous_keys_next  = cur_keys;
          latest_pressed_next = NOTE_NONE;
          key_cnt_next        = '0;
          state_next          = ST_INIT;
        end
      end
      ST_INIT: begin
        // base = octave * 12 = octave * 8 + octave * 4
        add_a      = {1'b0, octave, 3'b000};
        add_b      = {2'b00, octave, 2'b00};
        base_next  = add_sum;
        state_next = ST_KEY;
      end
      ST_KEY: begin
        if (key_cnt == KEY_CNT_W'(KEY_SCAN)) begin
          state_next = ST_STATUS;
        end else if (edge_on[key_cnt[KEY_IDX_W-1:0]] ||
                     edge_off[key_cnt[KEY_IDX_W-1:0]]) begin
          key_on_next = edge_on[key_cnt[KEY_IDX_W-1:0]];
          slot_next   = '0;
          state_next  = ST_EMIT;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_EMIT: begin
        add_b = chord_off;
        if (slot != '0 && chord_off == 8'd0) begin
          // unused chord slot
          if (slot == SLOT_W'(CHORD_SLOTS)) state_next = ST_NEXT;
          else slot_next = slot + 1'b1;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_last_next  = 1'b0;
          out_data_next  = '0;
          out_data_next[19:12] = add_sum;
          out_data_next[26:20] = NOTE_VELOCITY;
          if (key_on) begin
            out_user_next       = KIND_NOTE_ON;
            out_data_next[3:0]  = CIN_NOTE_ON;
            out_data_next[11:4] = STS_NOTE_ON;
            note_on_count_next  = note_on_count + 8'd1;
            if (slot == '0) latest_pressed_next = base;
          end else begin
            out_user_next       = KIND_NOTE_OFF;
            out_data_next[3:0]  = CIN_NOTE_OFF;
            out_data_next[11:4] = STS_NOTE_OFF;
          end
          if (slot == SLOT_W'(CHORD_SLOTS)) state_next = ST_NEXT;
          else slot_next = slot + 1'b1;
        end
      end
      ST_NEXT: begin
        add_b        = 8'd1;
        base_next    = add_sum;
        key_cnt_next = key_cnt + 1'b1;
        state_next   = ST_KEY;
      end
      ST_STATUS: begin
        if (out_free) begin
          out_valid_next        = 1'b1;
          out_last_next         = 1'b1;
          out_user_next         = KIND_STATUS;
          out_data_next         = '0;
          out_data_next[3:0]    = CIN_STATUS;
          out_data_next[30:27]  = disco_enable ? note_on_count[3:0] : 4'd0;
          out_data_next[38:31]  = latest_pressed;
          state_next            = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_keys  <= '1;
      note_on_count  <= 8'd0;
      latest_pressed <= NOTE_NONE;
      out_valid      <= 1'b0;
      key_cnt        <= '0;
      slot           <= '0;
    end else begin
      previous_keys  <= previous_keys_next;
      note_on_count  <= note_on_count_next;
      latest_pressed <= latest_pressed_next;
      out_valid      <= out_valid_next;
      key_cnt        <= key_cnt_next;
      slot           <= slot_next;
    end
    edge_on  <= edge_on_next;
    edge_off <= edge_off_next;
    key_on   <= key_on_next;
    base     <= base_next;
    out_data <= out_data_next;
    out_user <= out_user_next;
    out_last <= out_last_next;
  end

endmodule

`default_nettype wire
